// ----- rtl/sme_pkg.sv -----
// Shared types and constants of the stack machine executor.
package sme_pkg;
  localparam int unsigned DefStackDepth = 1024;
  localparam int unsigned DefDataWidth  = 32;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5,
    OP_PRINT = 3'd6,
    OP_NOP   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_HALTED    = 3'd4
  } status_e;

  // Datapath operations issued by the controller.
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_e;

  typedef struct packed {
    logic load_imm;  // latch the immediate into operand a
    logic load_a;    // latch RAM read data into operand a
    logic load_b;    // latch RAM read data into operand b
    logic start;     // start an arithmetic operation
    alu_e alu_op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;      // arithmetic result ready
    logic a_zero;    // operand a is zero
  } dp_status_t;
endpackage

// ----- rtl/sme_ram.sv -----
// Generic single-port RAM with registered read.
module sme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/sme_datapath.sv -----
// Operand registers and iterative multiply/divide unit.
module sme_datapath #(
  parameter int unsigned DataWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sme_pkg::dp_cmd_t       cmd_i,
  input  logic [DataWidth-1:0]   imm_i,
  input  logic [DataWidth-1:0]   rdata_i,
  output sme_pkg::dp_status_t    status_o,
  output logic [DataWidth-1:0]   a_o,
  output logic [DataWidth-1:0]   result_o
);
  import sme_pkg::*;

  localparam int unsigned CntW = $clog2(DataWidth + 1);

  logic [DataWidth-1:0] a_q, b_q, acc_q, acc_d, sh_q, sh_d, rem_q, rem_d;
  logic [DataWidth-1:0] res_q, res_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  alu_e                 op_q, op_d;
  logic [DataWidth-1:0] mag_a, mag_b;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] rem_sh;

  assign mag_a = a_q[DataWidth-1] ? (~a_q + 1'b1) : a_q;
  assign mag_b = b_q[DataWidth-1] ? (~b_q + 1'b1) : b_q;
  assign rem_sh = {rem_q[DataWidth-2:0], sh_q[DataWidth-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, acc_q};

  always_comb begin
    acc_d = acc_q; sh_d = sh_q; rem_d = rem_q; res_d = res_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0; neg_d = neg_q; op_d = op_q;
    if (cmd_i.start) begin
      op_d = cmd_i.alu_op;
      unique case (cmd_i.alu_op)
        ALU_ADD: begin res_d = b_q + a_q; done_d = 1'b1; end
        ALU_SUB: begin res_d = b_q - a_q; done_d = 1'b1; end
        ALU_MUL: begin
          // Shift-add: acc holds the product, sh the multiplier b.
          acc_d = '0; sh_d = b_q; rem_d = a_q;
          cnt_d = CntW'(DataWidth); busy_d = 1'b1;
        end
        default: begin
          // Restoring division of |b| by |a|; sh shifts out dividend bits.
          acc_d = mag_a; sh_d = mag_b; rem_d = '0;
          neg_d = a_q[DataWidth-1] ^ b_q[DataWidth-1];
          cnt_d = CntW'(DataWidth); busy_d = 1'b1;
        end
      endcase
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        if (sh_q[0]) acc_d = acc_q + rem_q;
        sh_d  = sh_q >> 1;
        rem_d = rem_q << 1;
      end else begin
        sh_d = sh_q << 1;
        if (!trial[DataWidth]) begin
          rem_d = trial[DataWidth-1:0];
          sh_d[0] = 1'b1;
        end else begin
          rem_d = rem_sh;
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == ALU_MUL) begin
          res_d = sh_q[0] ? acc_q + rem_q : acc_q;
        end else begin
          res_d = neg_q ? (~sh_d + 1'b1) : sh_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_imm) a_q <= imm_i;
    else if (cmd_i.load_a) a_q <= rdata_i;
    if (cmd_i.load_b) b_q <= rdata_i;
    acc_q <= acc_d; sh_q <= sh_d; rem_q <= rem_d; res_q <= res_d;
    neg_q <= neg_d; op_q <= op_d;
  end

  assign status_o.done   = done_q;
  assign status_o.a_zero = (a_q == '0);
  assign a_o             = a_q;
  assign result_o        = res_q;
endmodule

// ----- rtl/sme_ctrl.sv -----
// Instruction sequencer: stack pointer, RAM access and response registers.
module sme_ctrl #(
  parameter int unsigned StackDepth = 1024,
  parameter int unsigned DataWidth  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [2:0]                    req_type_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [2:0]                    status_o,
  output logic                          print_valid_o,
  output logic [DataWidth-1:0]          print_value_o,
  output logic [10:0]                   depth_after_o,
  output sme_pkg::dp_cmd_t              cmd_o,
  input  sme_pkg::dp_status_t           dp_i,
  input  logic [DataWidth-1:0]          a_i,
  input  logic [DataWidth-1:0]          result_i,
  input  logic [DataWidth-1:0]          rdata_i,
  output logic                          we_o,
  output logic [$clog2(StackDepth)-1:0] addr_o,
  output logic [DataWidth-1:0]          wdata_o
);
  import sme_pkg::*;

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned DW = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_A, S_RD_B, S_LAT_B, S_EXEC, S_WAIT, S_PRINT, S_RESP
  } state_e;

  state_e          state_q;
  op_e             op_q;
  logic [DW-1:0]   sp_q;
  logic            halted_q, rsp_valid_q, pvalid_q;
  logic [2:0]      status_q;
  logic [DataWidth-1:0] pval_q;
  logic            busy_out;

  assign busy_out = rsp_valid_q && !rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && !busy_out;

  // Datapath commands, decoded from state and the request handshake.
  always_comb begin
    cmd_o = '0;
    cmd_o.load_imm = req_ready_o && req_valid_i && (op_e'(req_type_i) == OP_PUSH);
    cmd_o.load_a = (state_q == S_RD_B);
    cmd_o.load_b = (state_q == S_LAT_B);
    cmd_o.start  = (state_q == S_EXEC) && !(op_q == OP_DIV && dp_i.a_zero);
    unique case (op_q)
      OP_ADD:  cmd_o.alu_op = ALU_ADD;
      OP_SUB:  cmd_o.alu_op = ALU_SUB;
      OP_MUL:  cmd_o.alu_op = ALU_MUL;
      default: cmd_o.alu_op = ALU_DIV;
    endcase
  end

  always_comb begin
    we_o = 1'b0; wdata_o = a_i; addr_o = sp_q[AW-1:0];
    unique case (state_q)
      S_RD_A:  begin addr_o = AW'(sp_q - 1'b1); we_o = (op_q == OP_PUSH);
                     if (op_q == OP_PUSH) addr_o = sp_q[AW-1:0]; end
      S_RD_B:  addr_o = AW'(sp_q - 2'd2);
      S_WAIT:  begin addr_o = AW'(sp_q - 2'd2); we_o = dp_i.done;
                     wdata_o = result_i; end
      default: addr_o = AW'(sp_q - 1'b1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; op_q <= OP_NOP; sp_q <= '0; halted_q <= 1'b0;
      rsp_valid_q <= 1'b0; status_q <= ST_OK; pvalid_q <= 1'b0; pval_q <= '0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_valid_i && req_ready_o) begin
          op_q <= op_e'(req_type_i);
          pvalid_q <= 1'b0; pval_q <= '0; status_q <= ST_OK;
          if (halted_q) begin
            status_q <= ST_HALTED; state_q <= S_RESP;
          end else begin
            unique case (op_e'(req_type_i))
              OP_PUSH: if (sp_q == DW'(StackDepth)) begin
                status_q <= ST_OVERFLOW; halted_q <= 1'b1; state_q <= S_RESP;
              end else state_q <= S_RD_A;
              OP_POP: if (sp_q == '0) begin
                status_q <= ST_UNDERFLOW; halted_q <= 1'b1; state_q <= S_RESP;
              end else begin sp_q <= sp_q - 1'b1; state_q <= S_RESP; end
              OP_PRINT: if (sp_q == '0) begin
                status_q <= ST_UNDERFLOW; halted_q <= 1'b1; state_q <= S_RESP;
              end else state_q <= S_RD_A;
              OP_NOP: state_q <= S_RESP;
              default: if (sp_q < DW'(2)) begin
                status_q <= ST_UNDERFLOW; halted_q <= 1'b1; state_q <= S_RESP;
              end else state_q <= S_RD_A;
            endcase
          end
        end
        S_RD_A: begin
          if (op_q == OP_PUSH) begin
            sp_q <= sp_q + 1'b1; state_q <= S_RESP;
          end else if (op_q == OP_PRINT) state_q <= S_PRINT;
          else state_q <= S_RD_B;
        end
        S_PRINT: begin
          pvalid_q <= 1'b1; pval_q <= rdata_i; sp_q <= sp_q - 1'b1;
          state_q <= S_RESP;
        end
        S_RD_B:  state_q <= S_LAT_B;
        S_LAT_B: state_q <= S_EXEC;
        S_EXEC: begin
          if (op_q == OP_DIV && dp_i.a_zero) begin
            status_q <= ST_DIVZERO; halted_q <= 1'b1; state_q <= S_RESP;
          end else state_q <= S_WAIT;
        end
        S_WAIT: if (dp_i.done) begin
          sp_q <= sp_q - 1'b1; state_q <= S_RESP;
        end
        S_RESP: if (!busy_out) begin
          rsp_valid_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid_o   = rsp_valid_q;
  assign status_o      = status_q;
  assign print_valid_o = pvalid_q;
  assign print_value_o = pval_q;
  assign depth_after_o = 11'(sp_q);
endmodule

// ----- rtl/stack_machine_executor.sv -----
// Top level of the stack machine executor.
// Usage:
//   The request channel (req_valid_i/req_ready_o) carries one instruction per
//   beat: req_type_i and immediate_i. The response channel
//   (rsp_valid_o/rsp_ready_i) returns exactly one beat per instruction with
//   status, print flag and value, and the stack depth afterwards.
//   Multiply and divide run on the shift-add and restoring divide unit,
//   one bit per cycle.
//   Instructions are processed one at a time; the next request is taken at
//   the earliest in the cycle in which the response beat leaves, so a new
//   instruction is never taken before the last one is through.
//   Reset empties the stack and clears the halted flag; stack memory keeps
//   stale data, which is never read at or above the stack pointer.
//   A stalled receiver holds the response register, and no new request is
//   taken until the response beat leaves.
//   After an error every instruction answers with the halted status.
module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = sme_pkg::DefStackDepth,
  parameter int unsigned DATA_WIDTH  = sme_pkg::DefDataWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [2:0]            req_type_i,
  input  logic [DATA_WIDTH-1:0] immediate_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output logic [2:0]            status_o,
  output logic                  print_valid_o,
  output logic [DATA_WIDTH-1:0] print_value_o,
  output logic [10:0]           depth_after_o
);
  import sme_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  dp_cmd_t               cmd;
  dp_status_t            dp_st;
  logic [DATA_WIDTH-1:0] a_val, result, rdata, wdata;
  logic                  we;
  logic [AW-1:0]         addr;

  sme_ctrl #(.StackDepth(STACK_DEPTH), .DataWidth(DATA_WIDTH)) u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_type_i,
    .rsp_valid_o, .rsp_ready_i, .status_o, .print_valid_o, .print_value_o,
    .depth_after_o, .cmd_o(cmd), .dp_i(dp_st), .a_i(a_val),
    .result_i(result), .rdata_i(rdata), .we_o(we), .addr_o(addr),
    .wdata_o(wdata)
  );

  sme_datapath #(.DataWidth(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .imm_i(immediate_i), .rdata_i(rdata),
    .status_o(dp_st), .a_o(a_val), .result_o(result)
  );

  sme_ram #(.Width(DATA_WIDTH), .Depth(STACK_DEPTH)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );
endmodule
